FILE: sv/lpfr_pkg.sv
// Shared types and constants of the length-prefixed file receiver.
package lpfr_pkg;

  // Event codes carried on the input tuser.
  localparam logic [1:0] ACT_START    = 2'd0;
  localparam logic [1:0] ACT_BYTE     = 2'd1;
  localparam logic [1:0] ACT_TICK     = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  // Characters sent back to the transmitter.
  localparam logic [7:0] CH_START = 8'h53;
  localparam logic [7:0] CH_ACK   = 8'h06;
  localparam logic [7:0] CH_NAK   = 8'h15;

  // Configuration register indexes.
  localparam logic CFG_MAX_LENGTH    = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam int unsigned LEN_W     = 17;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned ACC_W     = 24;
  localparam int unsigned LIMIT_W   = 25;
  localparam int unsigned OUT_TDATA_W = 56;

  // Capacity of the receive buffer in bytes.
  localparam int unsigned BUFFER_DEPTH = 65536;
  localparam logic [LIMIT_W-1:0] BUFFER_LIMIT = LIMIT_W'(BUFFER_DEPTH);

  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST    = 17'd65536;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

  typedef struct packed {
    logic             send_valid;
    logic [7:0]       send_char;
    logic             write_valid;
    logic [IDX_W-1:0] write_index;
    logic [7:0]       write_data;
    logic             finished;
    logic [LEN_W-1:0] received_length;
  } result_t;

endpackage

FILE: sv/lpfr_core.sv
// Transfer state, configuration registers and the per-event decision logic.
module lpfr_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [16:0]             cfg_data,
  input  logic                    ev_accept,
  input  logic [1:0]              ev_action,
  input  logic [7:0]              ev_byte,
  output logic                    res_valid,
  output lpfr_pkg::result_t       res
);
  import lpfr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_DATA
  } phase_t;

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   byte_count, byte_count_next;
  logic [ACC_W-1:0]   len_acc, len_acc_next;
  logic [TICK_W-1:0]  idle_ticks, idle_ticks_next;
  logic [LEN_W-1:0]   max_length;
  logic [TICK_W-1:0]  timeout_ticks;

  logic [LEN_W-1:0]   bc_inc;
  logic [TICK_W-1:0]  ticks_inc;
  logic [31:0]        full_len;
  logic [LIMIT_W-1:0] limit;

  assign bc_inc    = byte_count + LEN_W'(1);
  assign ticks_inc = (idle_ticks == {TICK_W{1'b1}}) ? idle_ticks
                                                    : idle_ticks + TICK_W'(1);
  assign full_len  = {ev_byte, len_acc};
  assign limit     = (LIMIT_W'(max_length) < BUFFER_LIMIT) ? LIMIT_W'(max_length)
                                                           : BUFFER_LIMIT;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    len_acc_next    = len_acc;
    idle_ticks_next = idle_ticks;
    res_valid       = 1'b0;
    res             = '0;
    case (ev_action)
      ACT_START: begin
        phase_next      = PH_LEN;
        byte_count_next = '0;
        len_acc_next    = '0;
        idle_ticks_next = '0;
        res_valid       = 1'b1;
        res.send_valid  = 1'b1;
        res.send_char   = CH_START;
      end
      ACT_BYTE: begin
        if (phase == PH_LEN) begin
          idle_ticks_next = '0;
          byte_count_next = bc_inc;
          case (byte_count[1:0])
            2'd0: len_acc_next[7:0]   = ev_byte;
            2'd1: len_acc_next[15:8]  = ev_byte;
            2'd2: len_acc_next[23:16] = ev_byte;
            default: begin
              // Fourth length byte: judge the complete little-endian length.
              byte_count_next = '0;
              if (full_len == 32'd0 || full_len > 32'(limit)) begin
                phase_next     = PH_IDLE;
                res_valid      = 1'b1;
                res.send_valid = 1'b1;
                res.send_char  = CH_NAK;
                res.finished   = 1'b1;
              end else begin
                phase_next   = PH_DATA;
                len_acc_next = full_len[ACC_W-1:0];
              end
            end
          endcase
        end else if (phase == PH_DATA) begin
          idle_ticks_next = '0;
          byte_count_next = bc_inc;
          res_valid       = 1'b1;
          res.write_valid = 1'b1;
          res.write_index = byte_count[IDX_W-1:0];
          res.write_data  = ev_byte;
          if (ACC_W'(bc_inc) >= len_acc) begin
            phase_next          = PH_IDLE;
            byte_count_next     = '0;
            res.send_valid      = 1'b1;
            res.send_char       = CH_ACK;
            res.finished        = 1'b1;
            res.received_length = len_acc[LEN_W-1:0];
          end
        end
      end
      ACT_TICK: begin
        if (phase != PH_IDLE) begin
          idle_ticks_next = ticks_inc;
          if (ticks_inc >= timeout_ticks) begin
            phase_next      = PH_IDLE;
            byte_count_next = '0;
            idle_ticks_next = '0;
            res_valid       = 1'b1;
            res.send_valid  = 1'b1;
            res.send_char   = CH_NAK;
            res.finished    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_count    <= '0;
      len_acc       <= '0;
      idle_ticks    <= '0;
      max_length    <= MAX_LENGTH_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else begin
      if (ev_accept) begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
        len_acc    <= len_acc_next;
        idle_ticks <= idle_ticks_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_LENGTH:    max_length    <= cfg_data;
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sv/lpfr_out_buf.sv
// Output register with a one-entry skid stage that holds a result while the output stalls.
module lpfr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lpfr_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfr_pkg::result_t out_data
);
  import lpfr_pkg::*;

  result_t skid_data;
  logic    skid_valid;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_ready || !out_valid) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        // Output is stalled and full: park the new result in the skid stage.
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (push && out_valid && !out_ready) begin
      skid_data <= push_data;
    end
  end

endmodule

FILE: sv/length_prefixed_file_receiver.sv
// Top level of the length-prefixed file receiver.
// Input events arrive on the s_ stream: tuser holds the event kind (start,
// received byte, millisecond tick) and tdata the received byte. A start
// answers 'S'; the next four bytes give a little-endian length. A bad length
// answers NAK and finishes with length 0; otherwise each data byte leaves as a
// buffer write, the last one together with ACK and the length. Too many ticks
// between bytes abort the transfer with NAK.
// Results leave on the m_ stream; an event causes at most one result, and
// tlast marks the one that ends a transfer.
// One event is accepted every cycle while s_tready is high; the result of an
// event is presented from the single output register.
// If the output stalls, one further result is held in a skid stage and
// s_tready drops until the output register drains it.
// The configuration channel is always ready; writes belong in idle periods.
// Reset (rst, synchronous) returns the block to idle, empties the output and
// restores max_length to 65536 and timeout_ticks to 1000.
module length_prefixed_file_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [lpfr_pkg::OUT_TDATA_W-1:0] m_tdata, // [7:0] send_char, [23:8] write_index,
                                 // [31:24] write_data, [48:32] received_length
  output logic [1:0]  m_tuser,   // [0] send_valid, [1] write_valid
  output logic        m_tlast,   // finished
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);
  import lpfr_pkg::*;

  logic    ev_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign ev_accept = s_tvalid && s_tready;

  lpfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev_accept (ev_accept),
    .ev_action (s_tuser),
    .ev_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (ev_accept && res_valid),
    .push_data (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {7'd0, out_res.received_length, out_res.write_data,
                    out_res.write_index, out_res.send_char};
  assign m_tuser = {out_res.write_valid, out_res.send_valid};
  assign m_tlast = out_res.finished;

endmodule
